// ===== rtl/v3r_pkg.sv =====
// Shared constants and elaboration-time trig helpers for the vector rotate/add/scale unit.
// No dependencies; used by v3r_trig, the unit top, its checker and its testbench.
`default_nettype none

package v3r_pkg;

  localparam int COORD_BITS_DEF     = 16;
  localparam int TRIG_FRAC_BITS_DEF = 16;
  localparam int SCALE_BITS         = 16;
  localparam int SCALE_FRAC_BITS    = 8;
  localparam int ANGLE_BITS         = 9;

  localparam longint HALF_TURN_DEG = 180;
  localparam longint PI_Q30        = 64'sd3373259426;
  localparam longint ONE_Q30       = 64'sd1 <<< 30;

  // request codes
  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_SUB    = 3'd1;
  localparam logic [2:0] OP_ROT_XY = 3'd2;
  localparam logic [2:0] OP_ROT_YZ = 3'd3;
  localparam logic [2:0] OP_ROT_XZ = 3'd4;
  localparam logic [2:0] OP_SCALE  = 3'd5;

  // The helpers below only build the constant sine/cosine table.
  function automatic longint mul_q30(longint a, longint b);
    return (a * b) >>> 30;
  endfunction

  function automatic longint rad_q30(longint k);
    return (k * PI_Q30 + HALF_TURN_DEG / 2) / HALF_TURN_DEG;
  endfunction

  // Taylor series, eight terms, Q30, 0..45 degrees
  function automatic longint q30_sin(longint k);
    longint x;
    longint t;
    longint acc;
    x   = rad_q30(k);
    t   = x;
    acc = x;
    t = mul_q30(mul_q30(t, x), x) / 6;    acc = acc - t;
    t = mul_q30(mul_q30(t, x), x) / 20;   acc = acc + t;
    t = mul_q30(mul_q30(t, x), x) / 42;   acc = acc - t;
    t = mul_q30(mul_q30(t, x), x) / 72;   acc = acc + t;
    t = mul_q30(mul_q30(t, x), x) / 110;  acc = acc - t;
    t = mul_q30(mul_q30(t, x), x) / 156;  acc = acc + t;
    t = mul_q30(mul_q30(t, x), x) / 210;  acc = acc - t;
    return acc;
  endfunction

  function automatic longint q30_cos(longint k);
    longint x;
    longint t;
    longint acc;
    x   = rad_q30(k);
    t   = ONE_Q30;
    acc = ONE_Q30;
    t = mul_q30(mul_q30(t, x), x) / 2;    acc = acc - t;
    t = mul_q30(mul_q30(t, x), x) / 12;   acc = acc + t;
    t = mul_q30(mul_q30(t, x), x) / 30;   acc = acc - t;
    t = mul_q30(mul_q30(t, x), x) / 56;   acc = acc + t;
    t = mul_q30(mul_q30(t, x), x) / 90;   acc = acc - t;
    t = mul_q30(mul_q30(t, x), x) / 132;  acc = acc + t;
    t = mul_q30(mul_q30(t, x), x) / 182;  acc = acc - t;
    return acc;
  endfunction

  // round half up from Q30 to frac_bits fraction bits
  function automatic longint to_frac(longint mag, int frac_bits);
    return (mag + (64'sd1 <<< (29 - frac_bits))) >>> (30 - frac_bits);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/vector3_rotate_add_scale_unit_top.sv =====
// Top level of the 3D vector unit: add, subtract, plane rotation and per-axis scale.
// Depends on v3r_pkg and v3r_trig.
`default_nettype none

// Five-stage pipeline that takes one word per cycle while in_stall is low and
// returns one word per word, in order. A result word is presented from the
// output register once its request has passed every stage, and is taken at an
// edge where the output side is not stalled. Stages: input register, angle
// reduction and sine/cosine lookup, multipliers, sum and truncate-toward-zero,
// saturate into the output register. Each stage holds only when the stage after
// it is full and holding, so empty slots are squeezed out and the input keeps
// flowing while a result waits, until every stage is full.
// Angles 360..511 wrap modulo 360; request codes 6 and 7 return A unchanged.
module vector3_rotate_add_scale_unit_top #(
  parameter int COORD_BITS     = v3r_pkg::COORD_BITS_DEF,
  parameter int TRIG_FRAC_BITS = v3r_pkg::TRIG_FRAC_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [2:0]                          in_req_type,
  input  wire logic signed [COORD_BITS-1:0]        in_a_x,
  input  wire logic signed [COORD_BITS-1:0]        in_a_y,
  input  wire logic signed [COORD_BITS-1:0]        in_a_z,
  input  wire logic signed [COORD_BITS-1:0]        in_b_x,
  input  wire logic signed [COORD_BITS-1:0]        in_b_y,
  input  wire logic signed [COORD_BITS-1:0]        in_b_z,
  input  wire logic [v3r_pkg::ANGLE_BITS-1:0]      in_angle_deg,
  input  wire logic signed [v3r_pkg::SCALE_BITS-1:0] in_scale_x,
  input  wire logic signed [v3r_pkg::SCALE_BITS-1:0] in_scale_y,
  input  wire logic signed [v3r_pkg::SCALE_BITS-1:0] in_scale_z,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [COORD_BITS-1:0]             out_r_x,
  output logic signed [COORD_BITS-1:0]             out_r_y,
  output logic signed [COORD_BITS-1:0]             out_r_z,
  output logic                                     out_clipped
);

  localparam int C   = COORD_BITS;
  localparam int F   = TRIG_FRAC_BITS;
  localparam int SB  = v3r_pkg::SCALE_BITS;
  localparam int SF  = v3r_pkg::SCALE_FRAC_BITS;
  localparam int AW  = v3r_pkg::ANGLE_BITS;
  localparam int TW  = F + 2;          // signed sine/cosine
  localparam int PW  = C + TW;         // rotation product
  localparam int DW  = PW + 1;         // rotation sum
  localparam int SW  = C + SB;         // scale product
  localparam int W   = C + 9;          // pre-saturation result

  localparam logic signed [DW-1:0] ROT_RND = {{(DW-F){1'b0}}, {F{1'b1}}};
  localparam logic signed [SW-1:0] SCL_RND = {{(SW-SF){1'b0}}, {SF{1'b1}}};
  localparam logic signed [W-1:0]  SAT_HI  = {{(W-C+1){1'b0}}, {(C-1){1'b1}}};
  localparam logic signed [W-1:0]  SAT_LO  = ~SAT_HI;

  // ---------------- handshake: bubble-collapsing advance chain
  logic v_a_r, v_b_r, v_c_r, v_d_r, v_e_r;
  logic adv_a, adv_b, adv_c, adv_d, adv_e;

  assign adv_e    = !v_e_r || !out_stall;
  assign adv_d    = !v_d_r || adv_e;
  assign adv_c    = !v_c_r || adv_d;
  assign adv_b    = !v_b_r || adv_c;
  assign adv_a    = !v_a_r || adv_b;
  assign in_stall = !adv_a;
  assign out_valid = v_e_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
      v_c_r <= 1'b0;
      v_d_r <= 1'b0;
      v_e_r <= 1'b0;
    end else begin
      if (adv_a) v_a_r <= in_valid;
      if (adv_b) v_b_r <= v_a_r;
      if (adv_c) v_c_r <= v_b_r;
      if (adv_d) v_d_r <= v_c_r;
      if (adv_e) v_e_r <= v_d_r;
    end
  end

  // ---------------- stage A: input register
  logic [2:0]              op_a_r;
  logic signed [C-1:0]     ax_a_r, ay_a_r, az_a_r, bx_a_r, by_a_r, bz_a_r;
  logic [AW-1:0]           ang_a_r;
  logic signed [SB-1:0]    sx_a_r, sy_a_r, sz_a_r;

  always_ff @(posedge clk) begin
    if (adv_a) begin
      op_a_r  <= in_req_type;
      ax_a_r  <= in_a_x;
      ay_a_r  <= in_a_y;
      az_a_r  <= in_a_z;
      bx_a_r  <= in_b_x;
      by_a_r  <= in_b_y;
      bz_a_r  <= in_b_z;
      ang_a_r <= in_angle_deg;
      sx_a_r  <= in_scale_x;
      sy_a_r  <= in_scale_y;
      sz_a_r  <= in_scale_z;
    end
  end

  // ---------------- stage B: sine/cosine lookup
  logic signed [TW-1:0] sin_nxt, cos_nxt;

  v3r_trig #(
    .TRIG_FRAC_BITS (F)
  ) u_trig (
    .angle_deg (ang_a_r),
    .sin_val   (sin_nxt),
    .cos_val   (cos_nxt)
  );

  logic [2:0]           op_b_r;
  logic signed [C-1:0]  ax_b_r, ay_b_r, az_b_r, bx_b_r, by_b_r, bz_b_r;
  logic signed [SB-1:0] sx_b_r, sy_b_r, sz_b_r;
  logic signed [TW-1:0] sin_b_r, cos_b_r;

  always_ff @(posedge clk) begin
    if (adv_b) begin
      op_b_r  <= op_a_r;
      ax_b_r  <= ax_a_r;
      ay_b_r  <= ay_a_r;
      az_b_r  <= az_a_r;
      bx_b_r  <= bx_a_r;
      by_b_r  <= by_a_r;
      bz_b_r  <= bz_a_r;
      sx_b_r  <= sx_a_r;
      sy_b_r  <= sy_a_r;
      sz_b_r  <= sz_a_r;
      sin_b_r <= sin_nxt;
      cos_b_r <= cos_nxt;
    end
  end

  // ---------------- stage C: multipliers
  // Rotation as p1 = u*c - v*s, p2 = u*s + v*c with (u,v) picked per plane.
  logic signed [C-1:0]  u_sel, v_sel;
  logic signed [PW-1:0] uc_nxt, vs_nxt, us_nxt, vc_nxt;
  logic signed [SW-1:0] px_nxt, py_nxt, pz_nxt;

  always_comb begin
    case (op_b_r)
      v3r_pkg::OP_ROT_YZ: begin
        u_sel = ay_b_r;
        v_sel = az_b_r;
      end
      v3r_pkg::OP_ROT_XZ: begin
        u_sel = az_b_r;
        v_sel = ax_b_r;
      end
      default: begin
        u_sel = ax_b_r;
        v_sel = ay_b_r;
      end
    endcase
    uc_nxt = PW'(u_sel) * PW'(cos_b_r);
    vs_nxt = PW'(v_sel) * PW'(sin_b_r);
    us_nxt = PW'(u_sel) * PW'(sin_b_r);
    vc_nxt = PW'(v_sel) * PW'(cos_b_r);
    px_nxt = SW'(ax_b_r) * SW'(sx_b_r);
    py_nxt = SW'(ay_b_r) * SW'(sy_b_r);
    pz_nxt = SW'(az_b_r) * SW'(sz_b_r);
  end

  logic [2:0]           op_c_r;
  logic signed [C-1:0]  ax_c_r, ay_c_r, az_c_r, bx_c_r, by_c_r, bz_c_r;
  logic signed [PW-1:0] uc_c_r, vs_c_r, us_c_r, vc_c_r;
  logic signed [SW-1:0] px_c_r, py_c_r, pz_c_r;

  always_ff @(posedge clk) begin
    if (adv_c) begin
      op_c_r <= op_b_r;
      ax_c_r <= ax_b_r;
      ay_c_r <= ay_b_r;
      az_c_r <= az_b_r;
      bx_c_r <= bx_b_r;
      by_c_r <= by_b_r;
      bz_c_r <= bz_b_r;
      uc_c_r <= uc_nxt;
      vs_c_r <= vs_nxt;
      us_c_r <= us_nxt;
      vc_c_r <= vc_nxt;
      px_c_r <= px_nxt;
      py_c_r <= py_nxt;
      pz_c_r <= pz_nxt;
    end
  end

  // ---------------- stage D: sums, truncate toward zero, select by op
  logic signed [DW-1:0] p1, p2, p1_sh, p2_sh;
  logic signed [SW-1:0] qx_sh, qy_sh, qz_sh;
  logic signed [W-1:0]  p1_w, p2_w;
  logic signed [W-1:0]  rx_nxt, ry_nxt, rz_nxt;

  always_comb begin
    p1 = DW'(uc_c_r) - DW'(vs_c_r);
    p2 = DW'(us_c_r) + DW'(vc_c_r);
    // negative values get the low-bit mask added so the shift rounds toward zero
    p1_sh = p1[DW-1] ? ((p1 + ROT_RND) >>> F) : (p1 >>> F);
    p2_sh = p2[DW-1] ? ((p2 + ROT_RND) >>> F) : (p2 >>> F);
    qx_sh = px_c_r[SW-1] ? ((px_c_r + SCL_RND) >>> SF) : (px_c_r >>> SF);
    qy_sh = py_c_r[SW-1] ? ((py_c_r + SCL_RND) >>> SF) : (py_c_r >>> SF);
    qz_sh = pz_c_r[SW-1] ? ((pz_c_r + SCL_RND) >>> SF) : (pz_c_r >>> SF);
    p1_w  = W'(p1_sh);
    p2_w  = W'(p2_sh);
    rx_nxt = W'(ax_c_r);
    ry_nxt = W'(ay_c_r);
    rz_nxt = W'(az_c_r);
    case (op_c_r)
      v3r_pkg::OP_ADD: begin
        rx_nxt = W'(ax_c_r) + W'(bx_c_r);
        ry_nxt = W'(ay_c_r) + W'(by_c_r);
        rz_nxt = W'(az_c_r) + W'(bz_c_r);
      end
      v3r_pkg::OP_SUB: begin
        rx_nxt = W'(ax_c_r) - W'(bx_c_r);
        ry_nxt = W'(ay_c_r) - W'(by_c_r);
        rz_nxt = W'(az_c_r) - W'(bz_c_r);
      end
      v3r_pkg::OP_ROT_XY: begin
        rx_nxt = p1_w;
        ry_nxt = p2_w;
      end
      v3r_pkg::OP_ROT_YZ: begin
        ry_nxt = p1_w;
        rz_nxt = p2_w;
      end
      v3r_pkg::OP_ROT_XZ: begin
        rx_nxt = p2_w;
        rz_nxt = p1_w;
      end
      v3r_pkg::OP_SCALE: begin
        rx_nxt = W'(qx_sh);
        ry_nxt = W'(qy_sh);
        rz_nxt = W'(qz_sh);
      end
      default: ;  // unused codes pass A through
    endcase
  end

  logic signed [W-1:0] rx_d_r, ry_d_r, rz_d_r;

  always_ff @(posedge clk) begin
    if (adv_d) begin
      rx_d_r <= rx_nxt;
      ry_d_r <= ry_nxt;
      rz_d_r <= rz_nxt;
    end
  end

  // ---------------- stage E: saturate into the output register
  logic signed [C-1:0] sx_nxt, sy_nxt, sz_nxt;
  logic                clip_nxt;
  logic                clx, cly, clz;

  always_comb begin
    clx = (rx_d_r > SAT_HI) || (rx_d_r < SAT_LO);
    cly = (ry_d_r > SAT_HI) || (ry_d_r < SAT_LO);
    clz = (rz_d_r > SAT_HI) || (rz_d_r < SAT_LO);
    sx_nxt = (rx_d_r > SAT_HI) ? SAT_HI[C-1:0] :
             (rx_d_r < SAT_LO) ? SAT_LO[C-1:0] : rx_d_r[C-1:0];
    sy_nxt = (ry_d_r > SAT_HI) ? SAT_HI[C-1:0] :
             (ry_d_r < SAT_LO) ? SAT_LO[C-1:0] : ry_d_r[C-1:0];
    sz_nxt = (rz_d_r > SAT_HI) ? SAT_HI[C-1:0] :
             (rz_d_r < SAT_LO) ? SAT_LO[C-1:0] : rz_d_r[C-1:0];
    clip_nxt = clx || cly || clz;
  end

  logic signed [C-1:0] rx_e_r, ry_e_r, rz_e_r;
  logic                clip_e_r;

  always_ff @(posedge clk) begin
    if (adv_e) begin
      rx_e_r   <= sx_nxt;
      ry_e_r   <= sy_nxt;
      rz_e_r   <= sz_nxt;
      clip_e_r <= clip_nxt;
    end
  end

  assign out_r_x     = rx_e_r;
  assign out_r_y     = ry_e_r;
  assign out_r_z     = rz_e_r;
  assign out_clipped = clip_e_r;

endmodule

`default_nettype wire

// ===== rtl/v3r_trig.sv =====
// Angle reduction and quarter-wave sine/cosine lookup, signed fixed point out.
// Depends on v3r_pkg for the table-building functions.
`default_nettype none

module v3r_trig #(
  parameter int TRIG_FRAC_BITS = v3r_pkg::TRIG_FRAC_BITS_DEF
) (
  input  wire logic [v3r_pkg::ANGLE_BITS-1:0] angle_deg,
  output logic signed [TRIG_FRAC_BITS+1:0]    sin_val,
  output logic signed [TRIG_FRAC_BITS+1:0]    cos_val
);

  localparam int TAB_W = TRIG_FRAC_BITS + 1;
  localparam int TRG_W = TRIG_FRAC_BITS + 2;
  localparam int AW    = v3r_pkg::ANGLE_BITS;

  localparam logic [AW-1:0] DEG_90  = AW'(90);
  localparam logic [AW-1:0] DEG_180 = AW'(180);
  localparam logic [AW-1:0] DEG_270 = AW'(270);
  localparam logic [AW-1:0] DEG_360 = AW'(360);

  logic [TAB_W-1:0] sin_tab [90];
  logic [TAB_W-1:0] cos_tab [90];

  // Magnitudes over one quadrant; above 45 degrees the complement is used.
  for (genvar k = 0; k < 90; k++) begin : g_tab
    localparam longint SQ = (k <= 45) ? v3r_pkg::q30_sin(longint'(k))
                                      : v3r_pkg::q30_cos(longint'(90 - k));
    localparam longint CQ = (k <= 45) ? v3r_pkg::q30_cos(longint'(k))
                                      : v3r_pkg::q30_sin(longint'(90 - k));
    assign sin_tab[k] = TAB_W'(v3r_pkg::to_frac(SQ, TRIG_FRAC_BITS));
    assign cos_tab[k] = TAB_W'(v3r_pkg::to_frac(CQ, TRIG_FRAC_BITS));
  end

  logic [AW-1:0]           deg_red;
  logic [AW-1:0]           rem_deg;
  logic [1:0]              quad;
  logic [6:0]              idx;
  logic signed [TRG_W-1:0] smag;
  logic signed [TRG_W-1:0] cmag;

  always_comb begin
    deg_red = (angle_deg >= DEG_360) ? angle_deg - DEG_360 : angle_deg;
    if (deg_red >= DEG_270) begin
      quad    = 2'd3;
      rem_deg = deg_red - DEG_270;
    end else if (deg_red >= DEG_180) begin
      quad    = 2'd2;
      rem_deg = deg_red - DEG_180;
    end else if (deg_red >= DEG_90) begin
      quad    = 2'd1;
      rem_deg = deg_red - DEG_90;
    end else begin
      quad    = 2'd0;
      rem_deg = deg_red;
    end
    idx  = rem_deg[6:0];
    smag = $signed({1'b0, sin_tab[idx]});
    cmag = $signed({1'b0, cos_tab[idx]});
    case (quad)
      2'd0: begin
        sin_val = smag;
        cos_val = cmag;
      end
      2'd1: begin
        sin_val = cmag;
        cos_val = -smag;
      end
      2'd2: begin
        sin_val = -smag;
        cos_val = -cmag;
      end
      default: begin
        sin_val = -cmag;
        cos_val = smag;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== test/vector3_unit_checker.sv =====
`timescale 1ns / 1ps
// Checker for the 3D vector unit: watches both channels, predicts each result word
// from the accepted request word and compares field by field. Depends on v3r_pkg.

module vector3_unit_checker (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  input  logic                                      in_stall,
  input  logic [2:0]                                in_req_type,
  input  logic signed [v3r_pkg::COORD_BITS_DEF-1:0] in_a_x,
  input  logic signed [v3r_pkg::COORD_BITS_DEF-1:0] in_a_y,
  input  logic signed [v3r_pkg::COORD_BITS_DEF-1:0] in_a_z,
  input  logic signed [v3r_pkg::COORD_BITS_DEF-1:0] in_b_x,
  input  logic signed [v3r_pkg::COORD_BITS_DEF-1:0] in_b_y,
  input  logic signed [v3r_pkg::COORD_BITS_DEF-1:0] in_b_z,
  input  logic [v3r_pkg::ANGLE_BITS-1:0]            in_angle_deg,
  input  logic signed [v3r_pkg::SCALE_BITS-1:0]     in_scale_x,
  input  logic signed [v3r_pkg::SCALE_BITS-1:0]     in_scale_y,
  input  logic signed [v3r_pkg::SCALE_BITS-1:0]     in_scale_z,
  input  logic                                      out_valid,
  input  logic                                      out_stall,
  input  logic signed [v3r_pkg::COORD_BITS_DEF-1:0] out_r_x,
  input  logic signed [v3r_pkg::COORD_BITS_DEF-1:0] out_r_y,
  input  logic signed [v3r_pkg::COORD_BITS_DEF-1:0] out_r_z,
  input  logic                                      out_clipped,
  output int                                        errors,
  output int                                        pending
);

  localparam int CW = v3r_pkg::COORD_BITS_DEF;
  localparam int FB = v3r_pkg::TRIG_FRAC_BITS_DEF;
  localparam int AW = v3r_pkg::ANGLE_BITS;
  localparam int SB = v3r_pkg::SCALE_BITS;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 clipped;
  } vec_result_t;

  vec_result_t expected_vectors[$];

  task automatic report_mismatch(input string msg);
    $display("[%0t] checker: %s", $time, msg);
    errors++;
  endtask

  // sine and cosine of 0..45 degrees in Q30, Taylor series of eight terms
  function automatic void series_q30(input longint deg, output longint s,
                                     output longint c);
    longint x;
    longint ts;
    longint tc;
    int n;
    x  = (deg * v3r_pkg::PI_Q30 + v3r_pkg::HALF_TURN_DEG / 2) / v3r_pkg::HALF_TURN_DEG;
    ts = x;
    tc = v3r_pkg::ONE_Q30;
    s  = x;
    c  = v3r_pkg::ONE_Q30;
    for (n = 1; n < 8; n++) begin
      ts = (((ts * x) >>> 30) * x >>> 30) / ((2 * n) * (2 * n + 1));
      tc = (((tc * x) >>> 30) * x >>> 30) / ((2 * n - 1) * (2 * n));
      if (n % 2 == 1) begin
        s = s - ts;
        c = c - tc;
      end else begin
        s = s + ts;
        c = c + tc;
      end
    end
  endfunction

  // fold the angle into 0..45, then round half up to FB fraction bits and sign
  function automatic void sincos_fixed(input logic [AW-1:0] angle,
                                       output longint s, output longint c);
    int d;
    int quad;
    int rem;
    longint ps;
    longint pc;
    longint ms;
    longint mc;
    logic ns;
    logic nc;
    d    = angle % 360;
    quad = d / 90;
    rem  = d % 90;
    if (rem <= 45) series_q30(rem, ps, pc);
    else series_q30(90 - rem, pc, ps);
    case (quad)
      0: begin
        ms = ps; ns = 1'b0; mc = pc; nc = 1'b0;
      end
      1: begin
        ms = pc; ns = 1'b0; mc = ps; nc = 1'b1;
      end
      2: begin
        ms = ps; ns = 1'b1; mc = pc; nc = 1'b1;
      end
      default: begin
        ms = pc; ns = 1'b1; mc = ps; nc = 1'b0;
      end
    endcase
    ms = (ms + (64'sd1 <<< (29 - FB))) >>> (30 - FB);
    mc = (mc + (64'sd1 <<< (29 - FB))) >>> (30 - FB);
    s  = ns ? -ms : ms;
    c  = nc ? -mc : mc;
  endfunction

  function automatic logic signed [CW-1:0] clamp_coord(input longint v, inout logic hit);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (CW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      hit = 1'b1;
      return hi[CW-1:0];
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo[CW-1:0];
    end
    return v[CW-1:0];
  endfunction

  function automatic vec_result_t predict_vector(
    input logic [2:0] op,
    input logic signed [CW-1:0] ax, ay, az, bx, by, bz,
    input logic [AW-1:0] angle,
    input logic signed [SB-1:0] sx, sy, sz
  );
    longint xa, ya, za, xb, yb, zb;
    longint kx, ky, kz;
    longint sin_v, cos_v, rx, ry, rz;
    longint trig_one, scale_one;
    logic hit;
    vec_result_t res;
    xa = ax; ya = ay; za = az;
    xb = bx; yb = by; zb = bz;
    kx = sx; ky = sy; kz = sz;
    rx = xa; ry = ya; rz = za;
    hit = 1'b0;
    sin_v = 0;
    cos_v = 0;
    trig_one  = 64'sd1 <<< FB;
    scale_one = 64'sd1 <<< v3r_pkg::SCALE_FRAC_BITS;
    if (op inside {v3r_pkg::OP_ROT_XY, v3r_pkg::OP_ROT_YZ, v3r_pkg::OP_ROT_XZ})
      sincos_fixed(angle, sin_v, cos_v);
    // signed division truncates toward zero, which is what the block does
    case (op)
      v3r_pkg::OP_ADD: begin
        rx = xa + xb; ry = ya + yb; rz = za + zb;
      end
      v3r_pkg::OP_SUB: begin
        rx = xa - xb; ry = ya - yb; rz = za - zb;
      end
      v3r_pkg::OP_ROT_XY: begin
        rx = (xa * cos_v - ya * sin_v) / trig_one;
        ry = (xa * sin_v + ya * cos_v) / trig_one;
      end
      v3r_pkg::OP_ROT_YZ: begin
        ry = (ya * cos_v - za * sin_v) / trig_one;
        rz = (ya * sin_v + za * cos_v) / trig_one;
      end
      v3r_pkg::OP_ROT_XZ: begin
        rx = (xa * cos_v + za * sin_v) / trig_one;
        rz = (za * cos_v - xa * sin_v) / trig_one;
      end
      v3r_pkg::OP_SCALE: begin
        rx = (xa * kx) / scale_one;
        ry = (ya * ky) / scale_one;
        rz = (za * kz) / scale_one;
      end
      default: ;  // spare codes return A unchanged
    endcase
    res.x = clamp_coord(rx, hit);
    res.y = clamp_coord(ry, hit);
    res.z = clamp_coord(rz, hit);
    res.clipped = hit;
    return res;
  endfunction

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin : watch_channels
    vec_result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_vectors.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          want = expected_vectors.pop_front();
          if (out_r_x !== want.x)
            report_mismatch($sformatf("r_x got %0d want %0d", out_r_x, $signed(want.x)));
          if (out_r_y !== want.y)
            report_mismatch($sformatf("r_y got %0d want %0d", out_r_y, $signed(want.y)));
          if (out_r_z !== want.z)
            report_mismatch($sformatf("r_z got %0d want %0d", out_r_z, $signed(want.z)));
          if (out_clipped !== want.clipped)
            report_mismatch($sformatf("clipped got %b want %b", out_clipped, want.clipped));
        end
      end
      if (in_valid && !in_stall) begin
        expected_vectors.push_back(predict_vector(in_req_type, in_a_x, in_a_y, in_a_z,
                                                  in_b_x, in_b_y, in_b_z, in_angle_deg,
                                                  in_scale_x, in_scale_y, in_scale_z));
      end
      pending = expected_vectors.size();
    end
  end

endmodule

// ===== test/tb_vector3_rotate_add_scale_unit_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the 3D vector unit: clock, reset, request words with random gaps,
// random result stalls, watchdog and verdict. Depends on v3r_pkg and vector3_unit_checker.

module tb_vector3_rotate_add_scale_unit_top;

  localparam int CW           = v3r_pkg::COORD_BITS_DEF;
  localparam int AW           = v3r_pkg::ANGLE_BITS;
  localparam int SB           = v3r_pkg::SCALE_BITS;
  localparam int RANDOM_WORDS = 700;
  localparam int IDLE_LIMIT   = 1000;
  localparam int TAIL_CYCLES  = 20;

  // request codes the block treats as pass-through
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [2:0]                    in_req_type;
  logic signed [CW-1:0]          in_a_x;
  logic signed [CW-1:0]          in_a_y;
  logic signed [CW-1:0]          in_a_z;
  logic signed [CW-1:0]          in_b_x;
  logic signed [CW-1:0]          in_b_y;
  logic signed [CW-1:0]          in_b_z;
  logic [AW-1:0]                 in_angle_deg;
  logic signed [SB-1:0]          in_scale_x;
  logic signed [SB-1:0]          in_scale_y;
  logic signed [SB-1:0]          in_scale_z;
  logic                          out_valid;
  logic                          out_stall;
  logic signed [CW-1:0]          out_r_x;
  logic signed [CW-1:0]          out_r_y;
  logic signed [CW-1:0]          out_r_z;
  logic                          out_clipped;
  int                            errors;
  int                            pending;
  int                            free_run;

  vector3_rotate_add_scale_unit_top DUT (.*);

  vector3_unit_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int rand_coord();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return -32768;
      1: return 32767;
      2: return int'($urandom_range(0, 64)) - 32;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  function automatic int rand_scale();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return -32768;
      1: return 32767;
      2, 3: return 256 + int'($urandom_range(0, 64)) - 32;
      4: return int'($urandom_range(0, 512)) - 256;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  function automatic int rand_angle();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      7: return 45 * $urandom_range(0, 7);
      8: return $urandom_range(360, 511);
      9: return $urandom_range(0, 511);
      default: return $urandom_range(0, 359);
    endcase
  endfunction

  function automatic logic [2:0] rand_op();
    if ($urandom_range(0, 99) < 95)
      return 3'($urandom_range(v3r_pkg::OP_ADD, v3r_pkg::OP_SCALE));
    return $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
  endfunction

  // mostly back to back, sometimes short gaps, rarely long ones
  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_word(input logic [2:0] op, input int ax, ay, az, bx, by, bz,
                           input int ang, sx, sy, sz);
    int gap;
    if (free_run > 0) begin
      free_run--;
      gap = 0;
    end else begin
      gap = rand_gap();
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_req_type  <= op;
    in_a_x       <= CW'(ax);
    in_a_y       <= CW'(ay);
    in_a_z       <= CW'(az);
    in_b_x       <= CW'(bx);
    in_b_y       <= CW'(by);
    in_b_z       <= CW'(bz);
    in_angle_deg <= AW'(ang);
    in_scale_x   <= SB'(sx);
    in_scale_y   <= SB'(sy);
    in_scale_z   <= SB'(sz);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin : result_backpressure
    int left;
    logic stalling;
    out_stall = 1'b0;
    left = 0;
    stalling = 1'b1;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        stalling = !stalling;
        if (stalling) begin
          case ($urandom_range(0, 19))
            0: left = $urandom_range(20, 50);
            1, 2, 3, 4, 5: left = $urandom_range(3, 8);
            default: left = $urandom_range(1, 2);
          endcase
        end else begin
          case ($urandom_range(0, 19))
            0, 1, 2: left = $urandom_range(40, 120);  // long stall-free stretch
            3, 4, 5, 6, 7, 8, 9: left = $urandom_range(5, 15);
            default: left = $urandom_range(1, 4);
          endcase
        end
      end
      left--;
      out_stall <= stalling;
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_req_type  = v3r_pkg::OP_ADD;
    in_a_x       = '0;
    in_a_y       = '0;
    in_a_z       = '0;
    in_b_x       = '0;
    in_b_y       = '0;
    in_b_z       = '0;
    in_angle_deg = '0;
    in_scale_x   = '0;
    in_scale_y   = '0;
    in_scale_z   = '0;
    free_run     = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extremes, every operation, wrap and saturation cases
    send_word(v3r_pkg::OP_ADD, 32767, 32767, 32767, 1, 0, 32767, 0, 0, 0, 0);
    send_word(v3r_pkg::OP_ADD, -32768, -32768, 100, -1, -32768, -200, 0, 0, 0, 0);
    send_word(v3r_pkg::OP_ADD, 1234, -5678, 0, -1234, 5678, 0, 0, 0, 0, 0);
    send_word(v3r_pkg::OP_SUB, -32768, 0, 32767, 32767, -32768, -1, 0, 0, 0, 0);
    send_word(v3r_pkg::OP_SUB, 10, -10, 0, 3, -7, 0, 0, 0, 0, 0);
    send_word(v3r_pkg::OP_ROT_XY, 32767, -32768, 77, 0, 0, 0, 0, 0, 0, 0);
    send_word(v3r_pkg::OP_ROT_XY, 1000, 2000, 3, 0, 0, 0, 90, 0, 0, 0);
    send_word(v3r_pkg::OP_ROT_XY, -32768, -32768, 5, 0, 0, 0, 180, 0, 0, 0);
    send_word(v3r_pkg::OP_ROT_XY, 32767, 32767, 0, 0, 0, 0, 45, 0, 0, 0);
    send_word(v3r_pkg::OP_ROT_XY, -777, 12345, 9, 0, 0, 0, 46, 0, 0, 0);
    send_word(v3r_pkg::OP_ROT_XY, 500, -500, 1, 0, 0, 0, 359, 0, 0, 0);
    send_word(v3r_pkg::OP_ROT_YZ, 42, -32768, 32767, 0, 0, 0, 270, 0, 0, 0);
    send_word(v3r_pkg::OP_ROT_YZ, 0, 20000, -15000, 0, 0, 0, 360, 0, 0, 0);
    send_word(v3r_pkg::OP_ROT_YZ, 1, 32767, 32767, 0, 0, 0, 225, 0, 0, 0);
    send_word(v3r_pkg::OP_ROT_XZ, -3, 8, 3, 0, 0, 0, 135, 0, 0, 0);
    send_word(v3r_pkg::OP_ROT_XZ, 32767, -1, -32768, 0, 0, 0, 315, 0, 0, 0);
    send_word(v3r_pkg::OP_ROT_XZ, 4321, 0, -4321, 0, 0, 0, 511, 0, 0, 0);
    send_word(v3r_pkg::OP_SCALE, 32767, -32768, 1234, 0, 0, 0, 0, 256, 256, 256);
    send_word(v3r_pkg::OP_SCALE, -32768, 32767, 100, 0, 0, 0, 0, -32768, 32767, 0);
    send_word(v3r_pkg::OP_SCALE, -3, 3, -255, 0, 0, 0, 0, 1, 1, 1);
    send_word(v3r_pkg::OP_SCALE, 300, -300, 7, 0, 0, 0, 0, -256, -129, 32767);
    send_word(OP_SPARE_LO, -32768, 32767, 0, 32767, 32767, 32767, 90, 512, 512, 512);
    send_word(OP_SPARE_HI, 1, -1, 32767, -32768, 0, 0, 180, 0, 0, 0);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if ($urandom_range(0, 49) == 0) free_run = $urandom_range(20, 40);
      send_word(rand_op(), rand_coord(), rand_coord(), rand_coord(),
                rand_coord(), rand_coord(), rand_coord(), rand_angle(),
                rand_scale(), rand_scale(), rand_scale());
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
